### hdl/iurs_pkg.sv
// Package for the ISO-TP / UDS request sequencer.
// Beat payload types, phase and step codes, and size constants. No dependencies.
package iurs_pkg;

  localparam int unsigned MAX_PAYLOAD = 4095;

  localparam logic [11:0] SAT_LEN      = 12'hFFF;
  localparam logic [12:0] MAX_REQ_LEN  = 13'(MAX_PAYLOAD);
  localparam logic [12:0] SF_MAX_LEN   = 13'd7;
  localparam logic [11:0] NEG_HELD_MAX = 12'd3;
  localparam logic [7:0]  WAIT_LIMIT_RST = 8'd8;

  localparam logic [7:0] SID_DSC  = 8'h10;
  localparam logic [7:0] SID_ER   = 8'h11;
  localparam logic [7:0] SID_CC   = 8'h28;
  localparam logic [7:0] SID_TP   = 8'h3E;
  localparam logic [7:0] SID_CDTC = 8'h85;
  localparam logic [8:0] POS_OFFSET = 9'h040;
  localparam logic [7:0] NEG_SID  = 8'h7F;
  localparam logic [7:0] NRC_PENDING = 8'h78;

  typedef enum logic [0:0] {
    OP_START = 1'b0,
    OP_DONE  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    FS_CTS  = 2'd0,
    FS_WAIT = 2'd1,
    FS_OVFL = 2'd2,
    FS_RSVD = 2'd3
  } flow_t;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_SF     = 3'd1,
    PH_FF     = 3'd2,
    PH_WAITFC = 3'd3,
    PH_CF     = 3'd4,
    PH_PEND   = 3'd5,
    PH_FC     = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    STEP_SF     = 3'd0,
    STEP_FF     = 3'd1,
    STEP_WAITFC = 3'd2,
    STEP_CF     = 3'd3,
    STEP_PEND   = 3'd4,
    STEP_FC     = 3'd5,
    STEP_DONE   = 3'd6
  } step_t;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_OVFLW  = 3'd1,
    ST_UNEXP  = 3'd2,
    ST_WFT    = 3'd3,
    ST_SUBERR = 3'd4
  } stat_t;

  typedef struct packed {
    logic        op;
    logic [12:0] length;
    logic [7:0]  byte_a;
    logic [7:0]  byte_b;
    logic [7:0]  byte_c;
    logic        functional;
    logic [3:0]  sub_status;
    logic [1:0]  flow_status;
    logic [11:0] reply_bytes_held;
    logic [11:0] progress;
  } in_beat_t;

  typedef struct packed {
    logic [2:0] next_step;
    logic [2:0] status;
    logic [3:0] sub_error;
  } out_beat_t;

  typedef struct packed {
    phase_t      phase;
    logic [11:0] request_bytes;
    logic [7:0]  service_id;
    logic        suppress_positive;
    logic [11:0] reply_bytes_expected;
    logic [7:0]  wait_count;
  } seq_state_t;

endpackage

### hdl/isotp_uds_request_sequencer.sv
// Top level of the ISO-TP / UDS request sequencer: beat registers, sequence state,
// WAIT limit register. Depends on iurs_pkg and iurs_step.
//
// Usage:
//   in_valid/in_stall/in_data carry event beats: start of a request (op 0) or
//   completion of the current frame subtask (op 1). Each accepted beat gives
//   exactly one out_data beat on out_valid/out_stall: the next step to take,
//   a status and, on subtask failure, the echoed subtask error code.
//   cfg_we/cfg_wdata write the WAIT frame limit (reset value 8); write it only
//   while no beat is in flight.
//   A beat moves from the input register through the decision logic into the
//   output register. Throughput: one beat per cycle unless out_stall holds a full
//   output register, set by the single input register feeding the decision logic
//   and output register. Sequence state updates as the result enters the output
//   register, so consecutive beats see each other's effect without bubbles.
//   Reset (rst_n low, synchronous) empties both beat registers, returns the
//   sequence to idle and sets the WAIT limit to 8.
//   While out_stall holds a full output register, the input register keeps its
//   beat and in_stall rises once it is occupied; nothing is dropped.
module isotp_uds_request_sequencer (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  iurs_pkg::in_beat_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output iurs_pkg::out_beat_t  out_data,
  input  logic                 cfg_we,
  input  logic [7:0]           cfg_wdata
);
  import iurs_pkg::*;

  localparam seq_state_t STATE_RST = '{
    phase:                PH_IDLE,
    request_bytes:        12'd0,
    service_id:           8'd0,
    suppress_positive:    1'b0,
    reply_bytes_expected: 12'd0,
    wait_count:           8'd0
  };

  logic       in_valid_r;
  logic       in_valid_nxt;
  in_beat_t   in_data_r;
  logic       out_valid_r;
  logic       out_valid_nxt;
  out_beat_t  out_data_r;
  out_beat_t  step_res;
  seq_state_t state_r;
  seq_state_t state_nxt;
  seq_state_t step_state;
  logic [7:0] wait_limit_r;
  logic       advance;
  logic       in_take;

  iurs_step u_step (
    .item       (in_data_r),
    .state      (state_r),
    .wait_limit (wait_limit_r),
    .result     (step_res),
    .state_nxt  (step_state)
  );

  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    in_valid_nxt  = in_take || (in_valid_r && !advance);
    out_valid_nxt = advance || (out_valid_r && out_stall);
    state_nxt     = advance ? step_state : state_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      state_r      <= STATE_RST;
      wait_limit_r <= WAIT_LIMIT_RST;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      state_r     <= state_nxt;
      if (cfg_we) begin
        wait_limit_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_data_r <= in_data;
    end
    if (advance) begin
      out_data_r <= step_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    advance && step_res.next_step == STEP_DONE |=> state_r.phase == PH_IDLE)
    else $error("sequence not idle after finish");

  a_status_only_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.status != ST_OK |-> out_data_r.next_step == STEP_DONE)
    else $error("nonzero status without finish");

  a_sub_error_tag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.sub_error != 4'd0 |-> out_data_r.status == ST_SUBERR)
    else $error("sub_error without subtask error status");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r && out_stall)
    else $error("input stalled with free output register");

  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !advance && !$past(!rst_n) |=> $stable(state_r))
    else $error("sequence state moved without a beat");

endmodule

### hdl/iurs_step.sv
// Next-step decision for one beat: combinational from the held beat and sequence state.
// Depends on iurs_pkg.
module iurs_step (
  input  iurs_pkg::in_beat_t   item,
  input  iurs_pkg::seq_state_t state,
  input  logic [7:0]           wait_limit,
  output iurs_pkg::out_beat_t  result,
  output iurs_pkg::seq_state_t state_nxt
);
  import iurs_pkg::*;

  logic [7:0]  b0;
  logic [7:0]  b1;
  logic [7:0]  b2;
  logic [11:0] rlen;
  logic        svc_suppr;
  step_t       cls_step;
  stat_t       cls_stat;
  phase_t      cls_phase;
  step_t       step;
  stat_t       stat;
  logic [3:0]  sub_err;

  assign b0   = (item.reply_bytes_held >= 12'd1) ? item.byte_a : 8'h00;
  assign b1   = (item.reply_bytes_held >= 12'd2) ? item.byte_b : 8'h00;
  assign b2   = (item.reply_bytes_held >= 12'd3) ? item.byte_c : 8'h00;
  assign rlen = item.length[12] ? SAT_LEN : item.length[11:0];

  assign svc_suppr = (item.byte_a == SID_DSC) || (item.byte_a == SID_ER) ||
                     (item.byte_a == SID_CC) || (item.byte_a == SID_TP) ||
                     (item.byte_a == SID_CDTC);

  // reply classification
  always_comb begin
    cls_step  = STEP_DONE;
    cls_stat  = ST_OK;
    cls_phase = PH_IDLE;
    priority if (item.length > SF_MAX_LEN) begin
      cls_step  = STEP_FC;
      cls_phase = PH_FC;
    end else if ({1'b0, b0} == ({1'b0, state.service_id} + POS_OFFSET)) begin
      cls_stat = ST_OK;
    end else if (b0 != NEG_SID || b1 != state.service_id ||
                 item.reply_bytes_held > NEG_HELD_MAX) begin
      cls_stat = ST_UNEXP;
    end else if (b2 != NRC_PENDING) begin
      cls_stat = ST_OK;
    end else begin
      cls_step  = STEP_PEND;
      cls_phase = PH_PEND;
    end
  end

  always_comb begin
    state_nxt = state;
    step      = STEP_DONE;
    stat      = ST_OK;
    sub_err   = 4'd0;
    if (item.op == OP_START) begin
      state_nxt.service_id           = item.byte_a;
      state_nxt.suppress_positive    = svc_suppr & item.byte_b[7];
      state_nxt.wait_count           = 8'd0;
      state_nxt.reply_bytes_expected = 12'd0;
      state_nxt.request_bytes        = item.length[12] ? SAT_LEN : item.length[11:0];
      priority if (item.length > MAX_REQ_LEN) begin
        stat = ST_OVFLW;
        state_nxt.phase = PH_IDLE;
      end else if (item.length > SF_MAX_LEN) begin
        if (item.functional) begin
          stat = ST_OVFLW;
          state_nxt.phase = PH_IDLE;
        end else begin
          step = STEP_FF;
          state_nxt.phase = PH_FF;
        end
      end else begin
        step = STEP_SF;
        state_nxt.phase = PH_SF;
      end
    end else if (state.phase == PH_IDLE) begin
      stat = ST_UNEXP;
    end else if (item.sub_status != 4'd0) begin
      stat    = ST_SUBERR;
      sub_err = item.sub_status;
      state_nxt.phase = PH_IDLE;
    end else begin
      unique case (state.phase)
        PH_SF, PH_PEND: begin
          state_nxt.reply_bytes_expected = rlen;
          if (state.suppress_positive && state.phase == PH_SF) begin
            state_nxt.phase = PH_IDLE;
          end else begin
            step = cls_step;
            stat = cls_stat;
            state_nxt.phase = cls_phase;
          end
        end
        PH_FF, PH_WAITFC: begin
          priority case (item.flow_status)
            FS_CTS: begin
              step = STEP_CF;
              state_nxt.phase = PH_CF;
            end
            FS_WAIT: begin
              if (state.wait_count >= wait_limit) begin
                stat = ST_WFT;
                state_nxt.phase = PH_IDLE;
              end else begin
                state_nxt.wait_count = state.wait_count + 8'd1;
                step = STEP_WAITFC;
                state_nxt.phase = PH_WAITFC;
              end
            end
            default: begin
              stat = ST_OVFLW;
              state_nxt.phase = PH_IDLE;
            end
          endcase
        end
        PH_CF: begin
          state_nxt.reply_bytes_expected = rlen;
          if (item.progress < state.request_bytes) begin
            step = STEP_CF;
            state_nxt.phase = PH_CF;
          end else if (state.suppress_positive) begin
            state_nxt.phase = PH_IDLE;
          end else begin
            step = cls_step;
            stat = cls_stat;
            state_nxt.phase = cls_phase;
          end
        end
        PH_FC: begin
          if (item.progress >= state.reply_bytes_expected) begin
            state_nxt.phase = PH_IDLE;
          end else begin
            step = STEP_FC;
            state_nxt.phase = PH_FC;
          end
        end
        default: begin
          stat = ST_UNEXP;
          state_nxt.phase = PH_IDLE;
        end
      endcase
    end
  end

  assign result.next_step = step;
  assign result.status    = stat;
  assign result.sub_error = sub_err;

endmodule

### tb/tb_top.sv
// Self-checking bench for isotp_uds_request_sequencer: directed and random event beats,
// checked beat by beat against a predictor of the sequence state kept in a scoreboard.
// Depends on iurs_pkg and the sequencer RTL.
module tb_top;
  import iurs_pkg::*;

  localparam logic [7:0] QUIET_SIDS [5] = '{SID_DSC, SID_ER, SID_CC, SID_TP, SID_CDTC};

  class seq_scoreboard;
    phase_t      phase;
    logic [11:0] request_bytes;
    logic [7:0]  service_id;
    logic        suppress;
    logic [11:0] reply_expected;
    logic [7:0]  wait_count;
    logic [7:0]  wait_limit;
    out_beat_t   step_q[$];
    int          n_events;
    int          n_errors;

    function new();
      phase = PH_IDLE;
      request_bytes = '0;
      service_id = '0;
      suppress = 1'b0;
      reply_expected = '0;
      wait_count = '0;
      wait_limit = WAIT_LIMIT_RST;
      n_events = 0;
      n_errors = 0;
    endfunction

    function out_beat_t finished(stat_t s);
      out_beat_t r;
      r.next_step = STEP_DONE;
      r.status = s;
      r.sub_error = 4'd0;
      phase = PH_IDLE;
      return r;
    endfunction

    function out_beat_t advance(step_t st, phase_t ph);
      out_beat_t r;
      r.next_step = st;
      r.status = ST_OK;
      r.sub_error = 4'd0;
      phase = ph;
      return r;
    endfunction

    // bytes beyond the held count read as zero
    function out_beat_t classify(in_beat_t b);
      int b0, b1, b2;
      b0 = (b.reply_bytes_held >= 12'd1) ? int'(b.byte_a) : 0;
      b1 = (b.reply_bytes_held >= 12'd2) ? int'(b.byte_b) : 0;
      b2 = (b.reply_bytes_held >= 12'd3) ? int'(b.byte_c) : 0;
      if (b.length > SF_MAX_LEN) return advance(STEP_FC, PH_FC);
      if (b0 == int'(service_id) + int'(POS_OFFSET)) return finished(ST_OK);
      if (b0 != int'(NEG_SID) || b1 != int'(service_id) || b.reply_bytes_held > NEG_HELD_MAX)
        return finished(ST_UNEXP);
      if (b2 != int'(NRC_PENDING)) return finished(ST_OK);
      return advance(STEP_PEND, PH_PEND);
    endfunction

    function out_beat_t flow_reply(logic [1:0] fs);
      if (fs == FS_CTS) return advance(STEP_CF, PH_CF);
      if (fs == FS_WAIT) begin
        if (wait_count >= wait_limit) return finished(ST_WFT);
        wait_count = wait_count + 8'd1;
        return advance(STEP_WAITFC, PH_WAITFC);
      end
      return finished(ST_OVFLW);
    endfunction

    function out_beat_t predict_step(in_beat_t b);
      out_beat_t r;
      logic [11:0] rlen;
      rlen = (b.length > {1'b0, SAT_LEN}) ? SAT_LEN : b.length[11:0];
      if (b.op == OP_START) begin
        service_id = b.byte_a;
        suppress = (b.byte_a inside {SID_DSC, SID_ER, SID_CC, SID_TP, SID_CDTC}) && b.byte_b[7];
        wait_count = '0;
        reply_expected = '0;
        request_bytes = rlen;
        if (b.length > MAX_REQ_LEN) r = finished(ST_OVFLW);
        else if (b.length > SF_MAX_LEN) begin
          if (b.functional) r = finished(ST_OVFLW);
          else r = advance(STEP_FF, PH_FF);
        end else r = advance(STEP_SF, PH_SF);
      end else if (phase == PH_IDLE) begin
        r = finished(ST_UNEXP);
      end else if (b.sub_status != 4'd0) begin
        r = finished(ST_SUBERR);
        r.sub_error = b.sub_status;
      end else begin
        case (phase)
          PH_SF: begin
            reply_expected = rlen;
            if (suppress) r = finished(ST_OK);
            else r = classify(b);
          end
          PH_FF, PH_WAITFC: begin
            r = flow_reply(b.flow_status);
          end
          PH_CF: begin
            reply_expected = rlen;
            if (b.progress >= request_bytes) begin
              if (suppress) r = finished(ST_OK);
              else r = classify(b);
            end else r = advance(STEP_CF, PH_CF);
          end
          PH_PEND: begin
            reply_expected = rlen;
            r = classify(b);
          end
          default: begin
            if (b.progress >= reply_expected) r = finished(ST_OK);
            else r = advance(STEP_FC, PH_FC);
          end
        endcase
      end
      return r;
    endfunction

    function void note_event(in_beat_t b);
      step_q.push_back(predict_step(b));
      n_events++;
    endfunction

    function void check_step(out_beat_t got);
      out_beat_t want;
      if (step_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 10)
          $display("unexpected result beat: step %0d status %0d sub %0d",
                   got.next_step, got.status, got.sub_error);
        return;
      end
      want = step_q.pop_front();
      if (got.next_step !== want.next_step || got.status !== want.status ||
          got.sub_error !== want.sub_error) begin
        n_errors++;
        if (n_errors <= 10)
          $display("result mismatch: expected step %0d status %0d sub %0d, got step %0d status %0d sub %0d",
                   want.next_step, want.status, want.sub_error,
                   got.next_step, got.status, got.sub_error);
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_data;
  logic      cfg_we = 1'b0;
  logic [7:0] cfg_wdata = 8'd0;
  bit        calm = 1'b0;

  seq_scoreboard sb;

  isotp_uds_request_sequencer dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  function automatic bit take_gap();
    return !calm && ($urandom_range(99) < 36);
  endfunction

  always @(posedge clk) begin
    out_stall <= take_gap();
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_step(out_data);
  end

  function automatic in_beat_t rand_beat();
    logic [95:0] raw;
    raw = {$urandom(), $urandom(), $urandom()};
    return raw[$bits(in_beat_t)-1:0];
  endfunction

  function automatic in_beat_t start_beat(int len, int sid, int subf, bit func);
    in_beat_t b;
    b = rand_beat();
    b.op = OP_START;
    b.length = 13'(len);
    b.byte_a = 8'(sid);
    b.byte_b = 8'(subf);
    b.functional = func;
    return b;
  endfunction

  function automatic in_beat_t done_beat(int sub, int fs, int len, int a, int bb, int c,
                                         int held, int prog);
    in_beat_t b;
    b = rand_beat();
    b.op = OP_DONE;
    b.sub_status = 4'(sub);
    b.flow_status = 2'(fs);
    b.length = 13'(len);
    b.byte_a = 8'(a);
    b.byte_b = 8'(bb);
    b.byte_c = 8'(c);
    b.reply_bytes_held = 12'(held);
    b.progress = 12'(prog);
    return b;
  endfunction

  // positive, negative, pending, multi-frame or garbage reply
  function automatic in_beat_t with_reply(in_beat_t b, logic [7:0] sid);
    int k;
    k = $urandom_range(99);
    b.reply_bytes_held = 12'($urandom_range(1, 3));
    b.length = 13'($urandom_range(1, 7));
    if (k < 30) begin
      b.byte_a = sid + 8'h40;
    end else if (k < 55) begin
      b.byte_a = NEG_SID;
      b.byte_b = sid;
      b.reply_bytes_held = 12'($urandom_range(2, 5));
      b.length = 13'($urandom_range(3, 7));
    end else if (k < 70) begin
      b.byte_a = NEG_SID;
      b.byte_b = sid;
      b.byte_c = NRC_PENDING;
      b.reply_bytes_held = 12'd3;
      b.length = 13'd3;
    end else if (k < 85) begin
      b.length = ($urandom_range(9) == 0) ? 13'($urandom()) : 13'($urandom_range(8, 300));
    end else begin
      b.length = 13'($urandom());
      b.reply_bytes_held = 12'($urandom());
    end
    return b;
  endfunction

  function automatic logic [11:0] progress_near(logic [11:0] lim);
    if ($urandom_range(99) < 40) return 12'($urandom_range(int'(lim), 4095));
    return 12'($urandom_range(0, int'(lim)));
  endfunction

  // caller stands at a rising edge; returns at the edge that took the beat
  task automatic send_beat(input in_beat_t b);
    while (take_gap()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_event(b);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.step_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic directed();
    send_beat(done_beat(0, 0, 3, 8'h62, 0, 0, 3, 0));
    send_beat(start_beat(0, 8'h22, 8'h00, 1'b0));
    send_beat(done_beat(0, 0, 3, 8'h62, 8'h01, 8'h02, 3, 0));
    send_beat(start_beat(7, SID_DSC, 8'h81, 1'b1));
    send_beat(done_beat(0, 0, 3, 0, 0, 0, 0, 0));
    send_beat(start_beat(8191, 8'hFF, 8'hFF, 1'b1));
    send_beat(start_beat(MAX_PAYLOAD + 1, SID_TP, 8'h80, 1'b0));
    send_beat(start_beat(64, 8'h2E, 8'h00, 1'b1));
    send_beat(start_beat(MAX_PAYLOAD, 8'h2E, 8'h00, 1'b0));
    send_beat(done_beat(0, FS_WAIT, 0, 0, 0, 0, 0, 0));
    send_beat(done_beat(0, FS_CTS, 0, 0, 0, 0, 0, 0));
    send_beat(done_beat(0, 0, 0, 0, 0, 0, 0, 100));
    send_beat(done_beat(0, 0, 3, NEG_SID, 8'h2E, 8'h31, 3, 4095));
    send_beat(start_beat(3, 8'h31, 8'h01, 1'b0));
    send_beat(done_beat(0, 0, 3, NEG_SID, 8'h31, NRC_PENDING, 3, 0));
    send_beat(done_beat(0, 0, 8191, 0, 0, 0, 0, 0));
    send_beat(done_beat(0, 0, 0, 0, 0, 0, 0, 4000));
    send_beat(done_beat(0, 0, 0, 0, 0, 0, 0, 4095));
    send_beat(start_beat(2, 8'h22, 8'h00, 1'b0));
    send_beat(done_beat(15, 0, 0, 0, 0, 0, 0, 0));
    send_beat(start_beat(9, 8'h22, 8'h00, 1'b0));
    send_beat(done_beat(0, FS_RSVD, 0, 0, 0, 0, 0, 0));
    send_beat(start_beat(9, 8'h22, 8'h00, 1'b0));
    send_beat(start_beat(5, 8'h22, 8'h00, 1'b0));
    send_beat(done_beat(0, 0, 3, 8'hFF, 8'hFF, 8'hFF, 0, 0));
    send_beat(start_beat(1, 8'h19, 8'h00, 1'b0));
    send_beat(done_beat(0, 0, 3, NEG_SID, 8'h19, NRC_PENDING, 4095, 0));
  endtask

  task automatic run_request();
    int k, len, sid, steps;
    in_beat_t b;
    k = $urandom_range(99);
    if (k < 60) len = $urandom_range(0, 7);
    else if (k < 90) len = $urandom_range(8, 64);
    else if (k < 96) len = $urandom_range(65, 4095);
    else len = $urandom_range(4096, 8191);
    k = $urandom_range(99);
    if (k < 35) sid = QUIET_SIDS[$urandom_range(4)];
    else sid = $urandom_range(255);
    send_beat(start_beat(len, sid, $urandom_range(255), $urandom_range(9) == 0));
    steps = 0;
    while (sb.phase != PH_IDLE && steps < 40) begin
      if ($urandom_range(99) < 2) break;
      b = with_reply(rand_beat(), sb.service_id);
      b.op = OP_DONE;
      b.sub_status = ($urandom_range(99) < 4) ? 4'($urandom_range(15, 1)) : 4'd0;
      k = $urandom_range(99);
      if (k < 55) b.flow_status = FS_CTS;
      else if (k < 90) b.flow_status = FS_WAIT;
      else if (k < 95) b.flow_status = FS_OVFL;
      else b.flow_status = FS_RSVD;
      if (sb.phase == PH_CF) b.progress = progress_near(sb.request_bytes);
      else if (sb.phase == PH_FC) b.progress = progress_near(sb.reply_expected);
      send_beat(b);
      steps++;
    end
  endtask

  task automatic run_phase(input logic [7:0] limit, input bit quiet);
    int target, k;
    in_beat_t b;
    settle();
    cfg_we <= 1'b1;
    cfg_wdata <= limit;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.wait_limit = limit;
    calm <= quiet;
    target = sb.n_events + 230;
    while (sb.n_events < target) begin
      k = $urandom_range(99);
      if (k < 82) begin
        run_request();
      end else if (k < 92) begin
        send_beat(rand_beat());
      end else begin
        b = rand_beat();
        b.op = OP_DONE;
        send_beat(b);
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed();
    run_phase(8'd0, 1'b0);
    run_phase(8'd255, 1'b1);
    run_phase(8'd1, 1'b0);
    run_phase(8'($urandom_range(2, 254)), 1'b0);
    run_phase(8'd3, 1'b0);
    calm <= 1'b0;
    settle();
    if (sb.n_errors == 0 && sb.step_q.size() == 0) begin
      $display("isotp_uds_request_sequencer regression: pass");
    end else begin
      $display("isotp_uds_request_sequencer regression: fail");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("isotp_uds_request_sequencer regression: fail");
    $finish;
  end

endmodule

### files.f
hdl/iurs_pkg.sv
hdl/iurs_step.sv
hdl/isotp_uds_request_sequencer.sv
tb/tb_top.sv
